@@ rtl/core/ccb_pkg.sv @@
`default_nettype none

package ccb_pkg;

    // Field widths of the transfer items.
    localparam int IDX_W    = 10;
    localparam int SIZE_W   = 33;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    // Bitmap word geometry: each memory row holds this many chunks.
    localparam int WORD_BITS = 32;
    localparam int WORD_LOG2 = 5;

    // Defaults for the top-level parameters.
    localparam int MAX_CHUNKS_DEF       = 1024;
    localparam int CHUNK_BYTES_LOG2_DEF = 22;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLAIM    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESTORE  = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] chunk_index;
    } ccb_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    granted_index;
        logic                all_claimed;
        logic [SIZE_W-1:0]   downloaded_bytes;
        logic                intact;
    } ccb_out_t;

endpackage

`default_nettype wire

@@ rtl/core/chunk_claim_bitmap.sv @@
`default_nettype none
// A claim scans the bitmap rows in order, one row of 32 chunks per cycle, at most
// MAX_CHUNKS/32 rows, and writes back the row holding the first free chunk; release, complete
// and restore take one memory read and one write back; a rejected index or a claim with no
// chunks goes straight to the result. A new item is accepted in the cycle after a result is
// loaded into the output register. Reset, and every write of file_size, start a clearing pass
// over every bitmap row during which no item is accepted.
module chunk_claim_bitmap #(
    parameter int MAX_CHUNKS       = ccb_pkg::MAX_CHUNKS_DEF,
    parameter int CHUNK_BYTES_LOG2 = ccb_pkg::CHUNK_BYTES_LOG2_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // Input channel.
    input  wire                          s_valid,
    output logic                         s_ready,
    input  ccb_pkg::ccb_in_t             s_data,
    // Result channel.
    output logic                         m_valid,
    input  wire                          m_ready,
    output ccb_pkg::ccb_out_t            m_data,
    // Configuration port.
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [ccb_pkg::PADDR_W-1:0]   paddr,
    input  wire [ccb_pkg::PDATA_W-1:0]   pwdata,
    output logic [ccb_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import ccb_pkg::*;

    // Storage geometry. Each memory row holds the claimed bits of 32 chunks in its low half
    // and their complete bits in its high half, so one read gives everything a command needs.
    localparam int WORDS = (MAX_CHUNKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int CW_A  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    // Width in which chunk indices and chunk counts are compared.
    localparam int CMP_W = (CW_A > WORD_LOG2 + AW) ? CW_A : (WORD_LOG2 + AW);
    localparam logic [AW-1:0] LAST_ROW = AW'(WORDS - 1);
    localparam logic [SIZE_W-1:0] UNIT = SIZE_W'(64'd1 << CHUNK_BYTES_LOG2);
    localparam logic [SIZE_W:0] UNIT_M1 = (SIZE_W + 1)'((64'd1 << CHUNK_BYTES_LOG2) - 64'd1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_RMW   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // The bitmap memory, with a registered read port.
    logic [2*WORD_BITS-1:0] mem [WORDS];
    logic [2*WORD_BITS-1:0] rd_data_reg;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [2*WORD_BITS-1:0] wr_data;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   file_size_reg, file_size_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SIZE_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]    claimed_cnt_reg, claimed_cnt_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [AW-1:0]       chk_reg, chk_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [CMP_W-1:0]    idx_reg, idx_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]    granted_reg, granted_next;
    logic                m_valid_reg, m_valid_next;
    ccb_out_t            m_data_reg, m_data_next;

    logic                 cfg_wr;
    logic [SIZE_W:0]      cfg_sum;
    logic [SIZE_W:0]      cfg_chunks;
    logic [CMP_W-1:0]     in_idx;
    logic [CMP_W-1:0]     scan_base;
    logic [CMP_W-1:0]     scan_lim;
    logic [WORD_BITS-1:0] scan_valid;
    logic [WORD_BITS-1:0] scan_free;
    logic [WORD_BITS-1:0] scan_onehot;
    logic [WORD_LOG2-1:0] scan_pos;
    logic [WORD_BITS-1:0] rd_claimed;
    logic [WORD_BITS-1:0] rd_complete;
    logic [WORD_BITS-1:0] idx_onehot;
    logic                 bit_claimed;
    logic                 bit_complete;
    logic [SIZE_W-1:0]    chunk_bytes;
    logic                 load_out;

    // ------------------------------------------------------------------
    // Configuration port. Only register 0 (file_size) exists; its 8-byte slot is selected
    // by paddr[3] being low. Reads of any other address return zero.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[3];
    assign prdata = (!paddr[3]) ? PDATA_W'(file_size_reg) : '0;

    // Chunk count of the incoming size: rounded up, then capped at the bitmap depth.
    assign cfg_sum    = {1'b0, pwdata[SIZE_W-1:0]} + UNIT_M1;
    assign cfg_chunks = cfg_sum >> CHUNK_BYTES_LOG2;

    // ------------------------------------------------------------------
    // Claim scan datapath: the row in rd_data_reg is row chk_reg. Only bits whose chunk
    // lies below the chunk count take part, and the lowest free one is picked by isolating
    // the lowest set bit of the free mask.
    // ------------------------------------------------------------------
    assign rd_claimed  = rd_data_reg[WORD_BITS-1:0];
    assign rd_complete = rd_data_reg[2*WORD_BITS-1:WORD_BITS];
    assign scan_base   = CMP_W'(chk_reg) << WORD_LOG2;
    assign scan_lim    = CMP_W'(count_reg) - scan_base;

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            scan_valid[b] = (CMP_W'(b) < scan_lim);
        end
    end

    assign scan_free   = ~rd_claimed & scan_valid;
    assign scan_onehot = scan_free & (~scan_free + WORD_BITS'(1));

    always_comb begin
        scan_pos = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (scan_onehot[b]) begin
                scan_pos = scan_pos | WORD_LOG2'(b);
            end
        end
    end

    // ------------------------------------------------------------------
    // Single-chunk datapath for release, complete and restore.
    // ------------------------------------------------------------------
    assign in_idx       = CMP_W'(s_data.chunk_index);
    assign idx_onehot   = WORD_BITS'(1) << idx_reg[WORD_LOG2-1:0];
    assign bit_claimed  = |(rd_claimed & idx_onehot);
    assign bit_complete = |(rd_complete & idx_onehot);
    // Every chunk below the count of whole units is full size; the last one holds the rest.
    assign chunk_bytes  = ((file_size_reg >> CHUNK_BYTES_LOG2) > SIZE_W'(idx_reg)) ?
                          UNIT : (file_size_reg & UNIT_M1[SIZE_W-1:0]);

    assign s_ready  = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // ------------------------------------------------------------------
    // Sequencer. One item is in flight at a time, and a write back is always followed by the
    // result cycle before the next read, so no access can see a stale row and no forwarding
    // path is needed.
    // ------------------------------------------------------------------
    always_comb begin
        state_next       = state_reg;
        file_size_next   = file_size_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        claimed_cnt_next = claimed_cnt_reg;
        clr_addr_next    = clr_addr_reg;
        chk_next         = chk_reg;
        cmd_next         = cmd_reg;
        idx_next         = idx_reg;
        status_next      = status_reg;
        granted_next     = granted_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        rd_addr          = chk_reg + AW'(1);
        wr_en            = 1'b0;
        wr_addr          = idx_reg[WORD_LOG2 +: AW];
        wr_data          = rd_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ROW) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                rd_addr = (s_data.command == CMD_CLAIM) ? '0 : in_idx[WORD_LOG2 +: AW];
                if (s_valid) begin
                    cmd_next     = s_data.command;
                    idx_next     = in_idx;
                    chk_next     = '0;
                    granted_next = '0;
                    status_next  = STATUS_OK;
                    if (s_data.command == CMD_CLAIM) begin
                        if (count_reg == '0) begin
                            status_next = STATUS_NOFREE;
                            state_next  = ST_DONE;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end else if (in_idx >= CMP_W'(count_reg)) begin
                        status_next = STATUS_RANGE;
                        state_next  = ST_DONE;
                    end else begin
                        state_next = ST_RMW;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_free != '0) begin
                    wr_en            = 1'b1;
                    wr_addr          = chk_reg;
                    wr_data          = {rd_complete, rd_claimed | scan_onehot};
                    claimed_cnt_next = claimed_cnt_reg + CNT_W'(1);
                    granted_next     = IDX_W'(scan_base | CMP_W'(scan_pos));
                    state_next       = ST_DONE;
                end else if (scan_lim <= CMP_W'(WORD_BITS)) begin
                    status_next = STATUS_NOFREE;
                    state_next  = ST_DONE;
                end else begin
                    chk_next = chk_reg + AW'(1);
                end
            end
            ST_RMW: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[WORD_LOG2 +: AW];
                case (cmd_reg)
                    CMD_RELEASE: begin
                        wr_data = {rd_complete, rd_claimed & ~idx_onehot};
                        if (bit_claimed) begin
                            claimed_cnt_next = claimed_cnt_reg - CNT_W'(1);
                        end
                    end
                    CMD_COMPLETE: begin
                        wr_data = {rd_complete | idx_onehot, rd_claimed};
                        if (!bit_complete) begin
                            total_next = total_reg + chunk_bytes;
                        end
                    end
                    CMD_RESTORE: begin
                        wr_data = {rd_complete | idx_onehot, rd_claimed | idx_onehot};
                        if (!bit_claimed) begin
                            claimed_cnt_next = claimed_cnt_reg + CNT_W'(1);
                        end
                        if (!bit_complete) begin
                            total_next = total_reg + chunk_bytes;
                        end
                    end
                    default: begin
                        wr_en = 1'b0;
                    end
                endcase
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) begin
                    m_valid_next                 = 1'b1;
                    m_data_next.status           = status_reg;
                    m_data_next.granted_index    = granted_reg;
                    m_data_next.all_claimed      = (claimed_cnt_reg == count_reg);
                    m_data_next.downloaded_bytes = total_reg;
                    m_data_next.intact           = (total_reg == file_size_reg);
                    state_next                   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        // A new size starts a new transfer: both bitmaps and the tallies are cleared.
        if (cfg_wr) begin
            file_size_next   = pwdata[SIZE_W-1:0];
            count_next       = (cfg_chunks > (SIZE_W + 1)'(MAX_CHUNKS)) ?
                               CNT_W'(MAX_CHUNKS) : cfg_chunks[CNT_W-1:0];
            total_next       = '0;
            claimed_cnt_next = '0;
            clr_addr_next    = '0;
            state_next       = ST_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            file_size_reg   <= '0;
            count_reg       <= '0;
            total_reg       <= '0;
            claimed_cnt_reg <= '0;
            clr_addr_reg    <= '0;
            chk_reg         <= '0;
            cmd_reg         <= CMD_CLAIM;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            file_size_reg   <= file_size_next;
            count_reg       <= count_next;
            total_reg       <= total_next;
            claimed_cnt_reg <= claimed_cnt_next;
            clr_addr_reg    <= clr_addr_next;
            chk_reg         <= chk_next;
            cmd_reg         <= cmd_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        m_data_reg  <= m_data_next;
    end

    // Bitmap memory: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The number of claimed chunks can never pass the chunk count.
    a_claimed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        claimed_cnt_reg <= count_reg)
        else $error("claimed chunk counter exceeds chunk count");

    // A size write starts the clearing pass, so no transfer is taken in the next cycle.
    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_ready)
        else $error("input accepted straight after a size write");

    // Only a successful claim reports a nonzero granted index.
    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STATUS_OK) |-> (m_data.granted_index == '0))
        else $error("granted index set on a failed command");

    // Memory writes only happen while clearing or finishing a command.
    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_CLEAR || state_reg == ST_SCAN || state_reg == ST_RMW))
        else $error("bitmap written outside clear, scan or update");

endmodule

`default_nettype wire

@@ tb/sv/tb_chunk_claim_bitmap.sv @@
`default_nettype none

// Testbench for chunk_claim_bitmap.
//
// The bench keeps its own copy of the claimed and complete bitmaps, the
// completed byte count and the file_size register. Every command transfer
// that the block accepts is run through that copy at the moment of
// acceptance. The reply it produces is queued. Each result transfer is then
// compared field by field with the oldest queued reply.
//
// The run is split into tests. A few directed ones cover the reset state,
// zero size, a short last chunk, repeated completion, indexes out of range
// and a size large enough to saturate the chunk count. Several random phases
// at different transfer sizes follow. Both channels stall at random, except
// in one long phase where neither side ever idles.
module tb_chunk_claim_bitmap;

    import ccb_pkg::*;

    localparam int          N_CHUNKS   = MAX_CHUNKS_DEF;
    localparam int          CHUNK_LOG2 = CHUNK_BYTES_LOG2_DEF;
    localparam longint unsigned CHUNK_UNIT = 64'd1 << CHUNK_LOG2;

    // file_size is the only register. It is 33 bits wide, so registers sit
    // on an 8-byte pitch and file_size sits at byte address zero.
    localparam logic [PADDR_W-1:0] ADDR_FILE_SIZE = PADDR_W'(0);

    // Cycles allowed after the last reply, enough for a full claim scan.
    localparam int TAIL_CYCLES = N_CHUNKS / WORD_BITS + 8;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    ccb_in_t             s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ccb_out_t            m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Chance, in percent, that either side idles in a given cycle.
    int                  stall_pct  = 33;
    int                  fail_count = 0;

    // The bench's own view of the block's state.
    bit                  claimed_bits [N_CHUNKS];
    bit                  done_bits    [N_CHUNKS];
    logic [SIZE_W-1:0]   done_bytes   = '0;
    logic [SIZE_W-1:0]   size_setting = '0;

    // Replies still owed by the block, oldest first.
    ccb_out_t            owed_replies [$];

    chunk_claim_bitmap #(
        .MAX_CHUNKS       (N_CHUNKS),
        .CHUNK_BYTES_LOG2 (CHUNK_LOG2)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Number of chunks: size divided by the chunk size, rounded up, and
    // saturated at the bitmap depth.
    function automatic int unsigned chunk_total();
        longint unsigned n;
        n = (64'(size_setting) + CHUNK_UNIT - 1) >> CHUNK_LOG2;
        if (n > N_CHUNKS) begin
            n = N_CHUNKS;
        end
        return int'(n);
    endfunction

    // Every chunk is full size except a short last one, which holds the
    // remainder of the size.
    function automatic longint unsigned chunk_bytes(int unsigned idx);
        if ((64'(size_setting) >> CHUNK_LOG2) > idx) begin
            return CHUNK_UNIT;
        end
        return 64'(size_setting) & (CHUNK_UNIT - 1);
    endfunction

    // A chunk's bytes are only counted the first time it completes.
    function automatic void mark_done(int unsigned idx);
        if (!done_bits[idx]) begin
            done_bits[idx] = 1'b1;
            done_bytes     = SIZE_W'(64'(done_bytes) + chunk_bytes(idx));
        end
    endfunction

    function automatic void clear_progress();
        for (int i = 0; i < N_CHUNKS; i++) begin
            claimed_bits[i] = 1'b0;
            done_bits[i]    = 1'b0;
        end
        done_bytes = '0;
    endfunction

    // Applies one command to the bench's state and returns the reply.
    function automatic ccb_out_t apply_command(ccb_in_t cmd_item);
        ccb_out_t    reply;
        int unsigned n;
        bit          found;
        n     = chunk_total();
        found = 1'b0;
        reply = '0;
        reply.status = STATUS_OK;
        if (cmd_item.command == CMD_CLAIM) begin
            // Lowest unclaimed chunk wins. With nothing free, claim fails.
            reply.status = STATUS_NOFREE;
            for (int unsigned i = 0; i < n && !found; i++) begin
                if (!claimed_bits[i]) begin
                    claimed_bits[i]     = 1'b1;
                    reply.granted_index = IDX_W'(i);
                    reply.status        = STATUS_OK;
                    found               = 1'b1;
                end
            end
        end else if (cmd_item.chunk_index >= n) begin
            reply.status = STATUS_RANGE;
        end else if (cmd_item.command == CMD_RELEASE) begin
            claimed_bits[cmd_item.chunk_index] = 1'b0;
        end else if (cmd_item.command == CMD_COMPLETE) begin
            mark_done(32'(cmd_item.chunk_index));
        end else begin
            claimed_bits[cmd_item.chunk_index] = 1'b1;
            mark_done(32'(cmd_item.chunk_index));
        end
        // With no chunks at all this stays set, which is the intended answer.
        reply.all_claimed = 1'b1;
        for (int unsigned i = 0; i < n; i++) begin
            if (!claimed_bits[i]) begin
                reply.all_claimed = 1'b0;
            end
        end
        reply.downloaded_bytes = done_bytes;
        reply.intact           = (done_bytes == size_setting);
        return reply;
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_field(input string name, input longint unsigned want,
                                input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // The receiver stalls at the same rate as the sender idles.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Every result transfer is matched against the oldest owed reply.
    always @(posedge aclk) begin : check_replies
        ccb_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_replies.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                fail_count++;
            end else begin
                want = owed_replies.pop_front();
                report_field("status", 64'(want.status), 64'(m_data.status));
                report_field("granted_index", 64'(want.granted_index),
                             64'(m_data.granted_index));
                report_field("all_claimed", 64'(want.all_claimed), 64'(m_data.all_claimed));
                report_field("downloaded_bytes", 64'(want.downloaded_bytes),
                             64'(m_data.downloaded_bytes));
                report_field("intact", 64'(want.intact), 64'(m_data.intact));
            end
        end
    end

    // ------------------------------------------------------------------
    // Command side and configuration
    // ------------------------------------------------------------------

    // Presents one command and returns at the edge where it is accepted.
    // Valid is only lowered while idling, so back-to-back commands keep it
    // high without a drop in between.
    task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
        ccb_in_t cmd_item;
        cmd_item.command     = cmd;
        cmd_item.chunk_index = idx;
        @(negedge aclk);
        while ($urandom_range(99) < stall_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd_item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        owed_replies = {owed_replies, apply_command(cmd_item)};
    endtask

    // Stops sending and waits until every owed reply has come back.
    task automatic wait_for_replies();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (owed_replies.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Writes file_size while the block is idle, then reads it back. The
    // write starts a new transfer, so the bench clears its own maps as well.
    task automatic set_file_size(input logic [SIZE_W-1:0] value);
        wait_for_replies();
        repeat (TAIL_CYCLES) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FILE_SIZE;
        pwdata  <= PDATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        size_setting = value;
        clear_progress();
        // Straight into the setup phase of the read-back.
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        report_field("file_size read-back", 64'(value), 64'(prdata[SIZE_W-1:0]));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random command with an index mostly inside the current chunk range,
    // and sometimes anywhere in the index field.
    task automatic send_random_command(input int unsigned n);
        int unsigned        pick;
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   idx;
        pick = $urandom_range(99);
        if (pick < 30) begin
            cmd = CMD_CLAIM;
        end else if (pick < 50) begin
            cmd = CMD_RELEASE;
        end else if (pick < 80) begin
            cmd = CMD_COMPLETE;
        end else begin
            cmd = CMD_RESTORE;
        end
        if (n > 0 && $urandom_range(99) < 85) begin
            idx = IDX_W'($urandom_range(n - 1, 0));
        end else begin
            idx = IDX_W'($urandom_range((1 << IDX_W) - 1, 0));
        end
        offer_command(cmd, idx);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // After reset the size is zero: no chunks, so claim finds nothing and
    // every index is out of range, while the transfer counts as intact.
    task automatic test_zero_size_after_reset();
        offer_command(CMD_CLAIM, '0);
        offer_command(CMD_RELEASE, '0);
        offer_command(CMD_COMPLETE, IDX_W'(5));
        offer_command(CMD_RESTORE, '1);
    endtask

    // Two chunks, the second one byte long: claiming to exhaustion, release
    // and re-claim, repeated completion, out-of-range indexes on release,
    // complete and restore, and a restore that finishes the transfer.
    task automatic test_short_last_chunk();
        set_file_size(SIZE_W'(CHUNK_UNIT + 1));
        offer_command(CMD_CLAIM, '1);
        offer_command(CMD_CLAIM, '0);
        offer_command(CMD_CLAIM, '0);
        offer_command(CMD_RELEASE, IDX_W'(0));
        offer_command(CMD_CLAIM, '0);
        offer_command(CMD_COMPLETE, IDX_W'(1));
        offer_command(CMD_COMPLETE, IDX_W'(1));
        offer_command(CMD_COMPLETE, IDX_W'(2));
        offer_command(CMD_RELEASE, IDX_W'(2));
        offer_command(CMD_RESTORE, '1);
        offer_command(CMD_RESTORE, IDX_W'(0));
        offer_command(CMD_RESTORE, IDX_W'(0));
        offer_command(CMD_RELEASE, IDX_W'(1));
    endtask

    // A size beyond the bitmap depth saturates the chunk count, so the top
    // index is a full chunk; one byte under the bitmap's capacity makes the
    // top chunk short instead.
    task automatic test_size_extremes();
        set_file_size('1);
        offer_command(CMD_RESTORE, '1);
        offer_command(CMD_COMPLETE, '1);
        offer_command(CMD_CLAIM, '1);
        set_file_size(SIZE_W'((64'(N_CHUNKS) << CHUNK_LOG2) - 1));
        offer_command(CMD_COMPLETE, '1);
    endtask

    // Random traffic at one transfer size. Now and then the sender holds off
    // until the block has answered everything outstanding.
    task automatic test_random_transfer(input logic [SIZE_W-1:0] size, input int count);
        int unsigned n;
        set_file_size(size);
        n = chunk_total();
        for (int k = 0; k < count; k++) begin
            send_random_command(n);
            if (k % 97 == 96) begin
                wait_for_replies();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        clear_progress();

        test_zero_size_after_reset();
        test_short_last_chunk();
        test_size_extremes();

        test_random_transfer(SIZE_W'((64'd3 << CHUNK_LOG2) +
                                     $urandom_range(32'(CHUNK_UNIT - 1), 1)), 150);
        test_random_transfer(SIZE_W'(64'd40 << CHUNK_LOG2), 200);
        test_random_transfer({1'($urandom_range(1, 0)), 32'($urandom())}, 150);
        // A long stretch in which neither side ever idles.
        stall_pct = 0;
        test_random_transfer(SIZE_W'(64'(N_CHUNKS) << CHUNK_LOG2), 400);
        stall_pct = 33;
        test_random_transfer(SIZE_W'((64'(N_CHUNKS) << CHUNK_LOG2) - 1), 300);
        test_random_transfer('1, 200);
        test_random_transfer(SIZE_W'(100), 100);
        test_random_transfer(SIZE_W'((64'd70 << CHUNK_LOG2) + 12345), 200);

        wait_for_replies();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard stop, several times the slowest correct run.
    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ chunk_claim_bitmap.f @@
rtl/core/ccb_pkg.sv
rtl/core/chunk_claim_bitmap.sv
tb/sv/tb_chunk_claim_bitmap.sv
